// ----- hdl/swt_pkg.sv -----
package swt_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT    = 2'd0,
    CMD_QUERY     = 2'd1,
    CMD_CLEAR     = 2'd2,
    CMD_CLEAR_ALL = 2'd3
  } cmd_e;

  localparam int unsigned SlotW   = 4;
  localparam int unsigned SigW    = 32;
  localparam int unsigned PidInW  = 8;
  localparam int unsigned PidMaxW = 16;

  // Command travelling down the row of cells, with the answer built so far.
  typedef struct packed {
    logic             valid;
    cmd_e             cmd;
    logic [SigW-1:0]  sig;
    logic             found;
    logic [SlotW-1:0] slot;
  } token_t;

endpackage

// ----- hdl/swt_cell.sv -----
module swt_cell #(
  parameter int unsigned CELL_INDEX   = 0,
  parameter int unsigned PROC_ID_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    advance_i,
  input  swt_pkg::token_t         tok_i,
  input  logic [PROC_ID_BITS-1:0] pid_i,
  output swt_pkg::token_t         tok_o,
  output logic [PROC_ID_BITS-1:0] pid_o
);
  import swt_pkg::*;

  localparam int unsigned SlotIdx = CELL_INDEX % (2 ** SlotW);

  logic                    entry_valid_q, entry_valid_d;
  logic [PROC_ID_BITS-1:0] entry_proc_q, entry_proc_d;
  logic [SigW-1:0]         entry_sig_q, entry_sig_d;
  token_t                  tok_q, tok_d;
  logic [PROC_ID_BITS-1:0] pid_q;
  logic                    proc_match;
  logic                    take;

  assign proc_match = entry_valid_q && (entry_proc_q == pid_i);
  assign take       = advance_i && tok_i.valid;

  always_comb begin
    tok_d         = tok_i;
    entry_valid_d = entry_valid_q;
    entry_proc_d  = entry_proc_q;
    entry_sig_d   = entry_sig_q;
    case (tok_i.cmd)
      CMD_INSERT: begin
        if (!tok_i.found && !entry_valid_q) begin
          entry_valid_d = 1'b1;
          entry_proc_d  = pid_i;
          entry_sig_d   = tok_i.sig;
          tok_d.found   = 1'b1;
          tok_d.slot    = SlotW'(SlotIdx);
        end
      end
      CMD_QUERY: begin
        if (!tok_i.found && proc_match && (entry_sig_q == tok_i.sig)) begin
          tok_d.found = 1'b1;
          tok_d.slot  = SlotW'(SlotIdx);
        end
      end
      CMD_CLEAR: begin
        if (proc_match) begin
          entry_valid_d = 1'b0;
        end
      end
      default: begin
        entry_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= 1'b0;
      tok_q         <= '0;
    end else begin
      if (take) begin
        entry_valid_q <= entry_valid_d;
      end
      if (advance_i) begin
        tok_q <= tok_d;
      end
    end
  end

  // Payload registers; a free entry's contents are never looked at.
  always_ff @(posedge clk_i) begin
    if (take) begin
      entry_proc_q <= entry_proc_d;
      entry_sig_q  <= entry_sig_d;
    end
    if (advance_i) begin
      pid_q <= pid_i;
    end
  end

  assign tok_o = tok_q;
  assign pid_o = pid_q;

  a_clear_all_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (tok_i.cmd == CMD_CLEAR_ALL) |=> !entry_valid_q)
    else $error("entry still valid after clear-all");

  a_found_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && tok_i.found |=> tok_q.found && (tok_q.slot == $past(tok_i.slot)))
    else $error("earlier match overwritten by a later cell");

  a_insert_claims_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (tok_i.cmd == CMD_INSERT) && !tok_i.found && !entry_valid_q
    |=> entry_valid_q && tok_q.found && (tok_q.slot == SlotW'(SlotIdx)))
    else $error("insert passed a free entry");

  a_used_entry_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (tok_i.cmd == CMD_INSERT) && entry_valid_q
    |=> entry_valid_q && ($past(entry_sig_q) == entry_sig_q))
    else $error("insert overwrote a used entry");

endmodule

// ----- hdl/signal_wait_table.sv -----
// Wait list of TABLE_ENTRIES entries, built as a row of cells that each own one entry.
// A command enters the first cell and moves one cell per clock unless the row stalls;
// each cell applies it to its own entry and passes along the lowest slot found so far.
// The row is a pipeline: a new command can be taken in every cycle that the row does
// not stall, and commands act on the table strictly in order. When the output holds
// a result that is not taken, the whole row stalls and in_ready_o drops. Reset
// empties the table at once. slot_o carries the low four bits of the index.
module signal_wait_table #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned PROC_ID_BITS  = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  command_i,
  input  logic [swt_pkg::PidInW-1:0]  proc_id_i,
  input  logic [swt_pkg::SigW-1:0]    sig_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic [swt_pkg::SlotW-1:0]   slot_o
);
  import swt_pkg::*;

  token_t                  tok   [TABLE_ENTRIES+1];
  logic [PROC_ID_BITS-1:0] pid   [TABLE_ENTRIES+1];
  logic [PidMaxW-1:0]      pid_ext;
  logic                    advance;
  logic                    out_valid_q;
  logic                    hit_q;
  logic [SlotW-1:0]        slot_q;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;

  // Only the low PROC_ID_BITS of the process id take part.
  assign pid_ext = {{(PidMaxW-PidInW){1'b0}}, proc_id_i};

  always_comb begin
    tok[0].valid = in_valid_i;
    tok[0].cmd   = cmd_e'(command_i);
    tok[0].sig   = sig_value_i;
    tok[0].found = 1'b0;
    tok[0].slot  = '0;
    pid[0]       = pid_ext[PROC_ID_BITS-1:0];
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    swt_cell #(
      .CELL_INDEX  (g),
      .PROC_ID_BITS(PROC_ID_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .advance_i(advance),
      .tok_i    (tok[g]),
      .pid_i    (pid[g]),
      .tok_o    (tok[g+1]),
      .pid_o    (pid[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= tok[TABLE_ENTRIES].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      hit_q  <= tok[TABLE_ENTRIES].found;
      slot_q <= tok[TABLE_ENTRIES].slot;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign slot_o      = slot_q;

  a_no_hit_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !hit_q |-> slot_q == '0)
    else $error("slot set without a hit");

  a_stall_holds_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(tok[TABLE_ENTRIES].valid) && out_valid_q)
    else $error("row moved while output stalled");

  a_clear_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && tok[TABLE_ENTRIES].valid &&
    ((tok[TABLE_ENTRIES].cmd == CMD_CLEAR) || (tok[TABLE_ENTRIES].cmd == CMD_CLEAR_ALL))
    |=> !hit_q)
    else $error("clear answered with a hit");

endmodule

// ----- bench/signal_wait_table_tb.sv -----
`timescale 1ns / 100ps

module signal_wait_table_tb;
  import swt_pkg::*;

  localparam int unsigned NumSlots   = 16;
  localparam int unsigned NumRandom  = 500;
  localparam int unsigned IdlePct    = 22;
  localparam int unsigned StallAt    = 150;
  localparam int unsigned StallLen   = 80;
  localparam int unsigned SteadyLo   = 300;
  localparam int unsigned SteadyHi   = 400;
  localparam int unsigned TailCycles = 40;

  typedef struct {
    cmd_e        cmd;
    logic [7:0]  pid;
    logic [31:0] sig;
    bit          drain;
  } wait_item_t;

  typedef struct {
    logic       hit;
    logic [3:0] slot;
  } wait_result_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i   = '0;
  logic [7:0]  proc_id_i   = '0;
  logic [31:0] sig_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        hit_o;
  logic [3:0]  slot_o;

  signal_wait_table #(
    .TABLE_ENTRIES(NumSlots),
    .PROC_ID_BITS (8)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .proc_id_i  (proc_id_i),
    .sig_value_i(sig_value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .hit_o      (hit_o),
    .slot_o     (slot_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  wait_item_t   pending_items[$];
  wait_result_t expected_results[$];

  // Shadow copy of the wait table.
  logic        table_valid[NumSlots];
  logic [7:0]  table_proc[NumSlots];
  logic [31:0] table_sig[NumSlots];

  int unsigned item_total = 0;
  int unsigned sent_cnt   = 0;
  int unsigned recv_cnt   = 0;
  int unsigned errors     = 0;
  int unsigned n_insert   = 0;
  int unsigned n_query    = 0;
  int unsigned n_clear    = 0;
  int unsigned n_full     = 0;
  int unsigned n_hit      = 0;
  int unsigned stall_left = 0;
  bit          stall_done = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s at result %0d: got %0h, expected %0h",
             $realtime, what, recv_cnt, got, want);
    errors++;
  endtask

  function automatic wait_result_t apply_command(input cmd_e cmd, input logic [7:0] pid,
                                                 input logic [31:0] sig);
    wait_result_t res;
    bit done;
    res.hit  = 1'b0;
    res.slot = '0;
    done     = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        n_insert++;
        for (int i = 0; i < NumSlots; i++) begin
          if (!done && !table_valid[i]) begin
            table_valid[i] = 1'b1;
            table_proc[i]  = pid;
            table_sig[i]   = sig;
            res.hit        = 1'b1;
            res.slot       = 4'(i);
            done           = 1'b1;
          end
        end
        if (!done) n_full++;
      end
      CMD_QUERY: begin
        n_query++;
        for (int i = 0; i < NumSlots; i++) begin
          if (!done && table_valid[i] && table_proc[i] == pid && table_sig[i] == sig) begin
            res.hit  = 1'b1;
            res.slot = 4'(i);
            done     = 1'b1;
          end
        end
      end
      CMD_CLEAR: begin
        n_clear++;
        for (int i = 0; i < NumSlots; i++) begin
          if (table_valid[i] && table_proc[i] == pid) begin
            table_valid[i] = 1'b0;
            table_proc[i]  = '0;
            table_sig[i]   = '0;
          end
        end
      end
      default: begin
        n_clear++;
        for (int i = 0; i < NumSlots; i++) begin
          table_valid[i] = 1'b0;
          table_proc[i]  = '0;
          table_sig[i]   = '0;
        end
      end
    endcase
    return res;
  endfunction

  // Driver: offers the pending items in order. An item marked drain is held back until
  // every earlier transfer has produced its result.
  always @(posedge clk_i) begin : drive_blk
    wait_item_t nxt;
    bit         took;
    bit         steady;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      took   = in_valid_i && in_ready_o;
      steady = (sent_cnt >= SteadyLo && sent_cnt < SteadyHi);
      if (took) sent_cnt <= sent_cnt + 1;
      if (!in_valid_i || took) begin
        if (pending_items.size() == 0 || (!steady && $urandom_range(99) < IdlePct)) begin
          in_valid_i <= 1'b0;
        end else if (pending_items[0].drain && (sent_cnt + int'(took) != recv_cnt)) begin
          in_valid_i <= 1'b0;
        end else begin
          nxt = pending_items.pop_front();
          in_valid_i  <= 1'b1;
          command_i   <= nxt.cmd;
          proc_id_i   <= nxt.pid;
          sig_value_i <= nxt.sig;
        end
      end
    end
  end

  // Receiver readiness, with one long hold-off that lets the row fill up.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (!stall_done && recv_cnt >= StallAt) begin
      stall_done  <= 1'b1;
      stall_left  <= StallLen;
      out_ready_i <= 1'b0;
    end else if (recv_cnt >= SteadyLo && recv_cnt < SteadyHi) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= IdlePct);
    end
  end

  // Monitor: checks the output transfer first, then records the input transfer of the
  // same edge, so the order of the two never depends on the scheduler.
  always @(posedge clk_i) begin : monitor_blk
    wait_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        recv_cnt <= recv_cnt + 1;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", {31'd0, hit_o}, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (hit_o !== want.hit) report_mismatch("hit", {31'd0, hit_o}, {31'd0, want.hit});
          if (slot_o !== want.slot) report_mismatch("slot", {28'd0, slot_o}, {28'd0, want.slot});
          if (want.hit) n_hit++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(apply_command(cmd_e'(command_i), proc_id_i, sig_value_i));
      end
    end
  end

  task automatic add_item(input cmd_e cmd, input logic [7:0] pid, input logic [31:0] sig,
                          input bit drain = 1'b0);
    wait_item_t it;
    it.cmd   = cmd;
    it.pid   = pid;
    it.sig   = sig;
    it.drain = drain;
    pending_items.push_back(it);
  endtask

  initial begin : stim_blk
    logic [7:0]  pid_pool[4];
    logic [31:0] sig_pool[4];
    int unsigned r;
    int unsigned mix;
    cmd_e        cmd;
    logic [7:0]  pid;
    logic [31:0] sig;

    for (int i = 0; i < NumSlots; i++) begin
      table_valid[i] = 1'b0;
      table_proc[i]  = '0;
      table_sig[i]   = '0;
    end

    // Every slot is still free, so this query of zeros must not match.
    add_item(CMD_QUERY, 8'h00, 32'h0000_0000);
    add_item(CMD_INSERT, 8'hFF, 32'hFFFF_FFFF);
    add_item(CMD_INSERT, 8'h00, 32'h0000_0000);
    // Duplicate entries; a query reports the lower slot.
    add_item(CMD_INSERT, 8'h05, 32'hA5A5_5A5A);
    add_item(CMD_INSERT, 8'h05, 32'hA5A5_5A5A);
    add_item(CMD_QUERY, 8'hFF, 32'hFFFF_FFFF);
    add_item(CMD_QUERY, 8'h00, 32'h0000_0000);
    add_item(CMD_QUERY, 8'h05, 32'hA5A5_5A5A);
    add_item(CMD_QUERY, 8'hFF, 32'hFFFF_FFFE);
    for (int i = 0; i < 12; i++) add_item(CMD_INSERT, 8'($urandom()), $urandom());
    // The table is full now, so this insert is refused.
    add_item(CMD_INSERT, 8'h33, 32'h1234_5678);
    add_item(CMD_CLEAR, 8'h05, 32'h0);
    add_item(CMD_QUERY, 8'h05, 32'hA5A5_5A5A);
    add_item(CMD_INSERT, 8'h5A, 32'h0F0F_F0F0);
    add_item(CMD_CLEAR, 8'h77, 32'h0);
    add_item(CMD_CLEAR_ALL, 8'h00, 32'h0);
    add_item(CMD_QUERY, 8'h5A, 32'h0F0F_F0F0);

    pid_pool[0] = 8'h00;
    pid_pool[1] = 8'hFF;
    pid_pool[2] = 8'($urandom());
    pid_pool[3] = 8'($urandom());
    sig_pool[0] = 32'h0000_0000;
    sig_pool[1] = 32'hFFFF_FFFF;
    sig_pool[2] = $urandom();
    sig_pool[3] = $urandom();

    // Mostly a small set of processes and signals so that queries hit and clears bite;
    // some fully random items toggle every payload bit.
    for (int n = 0; n < NumRandom; n++) begin
      r   = $urandom_range(99);
      mix = (n % 125 < 20) ? 90 : 45;
      if (r < mix) begin
        cmd = CMD_INSERT;
      end else if (r < mix + (100 - mix) * 6 / 10) begin
        cmd = CMD_QUERY;
      end else if (r < 97) begin
        cmd = CMD_CLEAR;
      end else begin
        cmd = CMD_CLEAR_ALL;
      end
      if ($urandom_range(99) < 15) begin
        pid = 8'($urandom());
        sig = $urandom();
      end else begin
        pid = pid_pool[$urandom_range(3)];
        sig = sig_pool[$urandom_range(3)];
      end
      add_item(cmd, pid, sig, (n == 0 || n == 250));
    end
    item_total = pending_items.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (sent_cnt == item_total && recv_cnt == item_total);
    repeat (TailCycles) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      report_mismatch("results left over", expected_results.size(), 32'd0);
    end
    $display("Ran %0d commands: %0d inserts, %0d queries, %0d clears.",
             recv_cnt, n_insert, n_query, n_clear);
    $display("Saw %0d hits and %0d inserts refused by a full table; %0d mismatches.",
             n_hit, n_full, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timed out with %0d of %0d results received.", recv_cnt, item_total);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- signal_wait_table.f -----
hdl/swt_pkg.sv
hdl/swt_cell.sv
hdl/signal_wait_table.sv
bench/signal_wait_table_tb.sv
